/* rtl/yawu_pkg.sv */
// Shared constants and types for the yaw unwrap and base offset unit.
`timescale 1ns / 1ps

package yawu_pkg;

    // Turn counter width and the fixed field widths.
    localparam int COUNT_WIDTH = 16;
    localparam int YAW_W       = 17;
    localparam int MODE_W      = 2;
    localparam int OFFSET_W    = 32;

    // count*36000 fits in COUNT_WIDTH+16 bits; adding a 17-bit yaw needs one more.
    localparam int ABS_W = COUNT_WIDTH + YAW_W;
    // Width used for the 32-bit saturation compare.
    localparam int EXT_W = (ABS_W > OFFSET_W + 1) ? ABS_W : OFFSET_W + 1;

    // Angles in hundredths of a degree.
    localparam int FULL_TURN    = 36000;
    localparam int HALF_TURN    = 18000;
    localparam int QUARTER_TURN = 9000;
    localparam int EIGHTH_TURN  = 4500;

    // Residue width: values below a half turn.
    localparam int RES_W = 15;

    typedef enum logic [MODE_W-1:0] {
        MODE_ABSOLUTE = 2'd0,
        MODE_HALF     = 2'd1,
        MODE_QUARTER  = 2'd2,
        MODE_ABS_ALT  = 2'd3
    } mode_t;

endpackage

/* rtl/yawu_offset_calc.sv */
// Absolute angle, saturation and base point fold for one registered sample.
`timescale 1ns / 1ps

module yawu_offset_calc
    import yawu_pkg::*;
(
    input  logic signed [COUNT_WIDTH-1:0] turn_count,
    input  logic signed [YAW_W-1:0]       yaw,
    input  mode_t                         mode,
    output logic signed [OFFSET_W-1:0]    offset
);

    localparam logic signed [ABS_W-1:0]   FULL_TURN_S = ABS_W'(FULL_TURN);
    localparam logic signed [YAW_W+1:0]   MOD_BIAS    = (YAW_W+2)'(4 * HALF_TURN);
    localparam logic [YAW_W:0]            SUB4        = (YAW_W+1)'(4 * HALF_TURN);
    localparam logic [YAW_W:0]            SUB2        = (YAW_W+1)'(2 * HALF_TURN);
    localparam logic [YAW_W:0]            SUB1        = (YAW_W+1)'(HALF_TURN);
    localparam logic [RES_W-1:0]          HALF_R      = RES_W'(HALF_TURN);
    localparam logic [RES_W-1:0]          QUARTER_R   = RES_W'(QUARTER_TURN);
    localparam logic [RES_W-1:0]          EIGHTH_R    = RES_W'(EIGHTH_TURN);
    localparam logic signed [EXT_W-1:0]   SAT_MAX     = EXT_W'({1'b0, {(OFFSET_W-1){1'b1}}});
    localparam logic signed [EXT_W-1:0]   SAT_MIN     = -SAT_MAX - EXT_W'(1);

    logic signed [ABS_W-1:0]    count_ext;
    logic signed [ABS_W-1:0]    turns_ang;
    logic signed [ABS_W-1:0]    abs_ang;
    logic signed [EXT_W-1:0]    abs_ext;
    logic                       abs_neg;
    logic signed [YAW_W+1:0]    biased;
    logic [YAW_W:0]             m_a;
    logic [YAW_W:0]             m_b;
    logic [YAW_W:0]             m_c;
    logic [RES_W-1:0]           m_half;
    logic [RES_W-1:0]           m_quarter;
    logic signed [RES_W:0]      fold_half;
    logic signed [RES_W:0]      fold_quarter;
    logic signed [OFFSET_W-1:0] abs_sat;

    // Whole turns are multiples of both base spacings, so only the yaw
    // residue and the sign of the absolute angle decide the fold.
    assign count_ext = ABS_W'(turn_count);
    assign turns_ang = count_ext * FULL_TURN_S;
    assign abs_ang   = turns_ang + ABS_W'(yaw);
    assign abs_ext   = EXT_W'(abs_ang);
    assign abs_neg   = abs_ang[ABS_W-1];

    // Floor residue of yaw modulo a half turn, by three compare-subtract steps.
    assign biased = (YAW_W+2)'(yaw) + MOD_BIAS;
    assign m_a    = biased[YAW_W:0];
    assign m_b    = (m_a >= SUB4) ? m_a - SUB4 : m_a;
    assign m_c    = (m_b >= SUB2) ? m_b - SUB2 : m_b;

    always_comb
    begin
        m_half    = (m_c >= SUB1) ? RES_W'(m_c - SUB1) : RES_W'(m_c);
        m_quarter = (m_half >= QUARTER_R) ? m_half - QUARTER_R : m_half;

        // Truncating division gives a negative remainder for negative angles,
        // which only changes the result exactly at the fold limit.
        if ((m_half > QUARTER_R) || ((m_half == QUARTER_R) && abs_neg))
        begin
            fold_half = $signed({1'b0, m_half}) - $signed({1'b0, HALF_R});
        end
        else
        begin
            fold_half = $signed({1'b0, m_half});
        end

        if ((m_quarter > EIGHTH_R) || ((m_quarter == EIGHTH_R) && abs_neg))
        begin
            fold_quarter = $signed({1'b0, m_quarter}) - $signed({1'b0, QUARTER_R});
        end
        else
        begin
            fold_quarter = $signed({1'b0, m_quarter});
        end

        if (abs_ext > SAT_MAX)
        begin
            abs_sat = SAT_MAX[OFFSET_W-1:0];
        end
        else if (abs_ext < SAT_MIN)
        begin
            abs_sat = SAT_MIN[OFFSET_W-1:0];
        end
        else
        begin
            abs_sat = abs_ext[OFFSET_W-1:0];
        end

        case (mode)
            MODE_HALF:    offset = OFFSET_W'(fold_half);
            MODE_QUARTER: offset = OFFSET_W'(fold_quarter);
            default:      offset = abs_sat;
        endcase
    end

endmodule

/* rtl/yaw_unwrap_base_offset_unit.sv */
// Top level of the multi-turn yaw unwrap and base point offset unit.
`timescale 1ns / 1ps

// Takes one wrapped yaw sample per transfer and returns one offset per sample,
// in hundredths of a degree. The unit accepts a new sample every clock cycle
// while the receiver does not hold the output. The transfer edge loads the
// sample stage, and a later edge loads the output register once the output
// is not held by the receiver. The turn counter is updated in the same cycle
// the sample is taken. Mode 0 or 3 returns the saturated absolute angle,
// mode 1 the offset to the nearest multiple of 180 degrees and mode 2 to the
// nearest multiple of 90 degrees. Reset clears the previous sample and the
// turn count to zero.
module yaw_unwrap_base_offset_unit
    import yawu_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [YAW_W-1:0]    yaw,
    input  logic [MODE_W-1:0]          mode,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [OFFSET_W-1:0] offset
);

    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic signed [YAW_W:0]         JUMP_POS = (YAW_W+1)'(HALF_TURN);
    localparam logic signed [YAW_W:0]         JUMP_NEG = -JUMP_POS;

    logic signed [YAW_W-1:0]       last_yaw_reg;
    logic signed [COUNT_WIDTH-1:0] count_reg;
    logic signed [COUNT_WIDTH-1:0] count_next;
    logic                          s1_valid_reg;
    logic signed [YAW_W-1:0]       s1_yaw_reg;
    mode_t                         s1_mode_reg;
    logic signed [COUNT_WIDTH-1:0] s1_count_reg;
    logic                          out_valid_reg;
    logic signed [OFFSET_W-1:0]    offset_reg;
    logic signed [OFFSET_W-1:0]    offset_next;
    logic signed [YAW_W:0]         diff;
    logic                          s1_advance;
    logic                          in_xfer;

    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_xfer    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign offset     = offset_reg;

    assign diff = (YAW_W+1)'(yaw) - (YAW_W+1)'(last_yaw_reg);

    always_comb
    begin
        count_next = count_reg;
        if (diff > JUMP_POS)
        begin
            if (count_reg != CNT_MIN)
            begin
                count_next = count_reg - COUNT_WIDTH'(1);
            end
        end
        else if (diff < JUMP_NEG)
        begin
            if (count_reg != CNT_MAX)
            begin
                count_next = count_reg + COUNT_WIDTH'(1);
            end
        end
    end

    yawu_offset_calc u_calc (
        .turn_count (s1_count_reg),
        .yaw        (s1_yaw_reg),
        .mode       (s1_mode_reg),
        .offset     (offset_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_yaw_reg  <= '0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                last_yaw_reg <= yaw;
                count_reg    <= count_next;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_yaw_reg   <= yaw;
            s1_mode_reg  <= mode_t'(mode);
            s1_count_reg <= count_next;
        end
        if (s1_advance && s1_valid_reg)
        begin
            offset_reg <= offset_next;
        end
    end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the yaw unwrap and base point offset unit.
`timescale 1ns / 1ps

module testbench;
    import yawu_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_SLACK = 10;
    localparam int MAX_REPORTS = 10;
    localparam longint RUN_LIMIT_NS = 20_000_000;

    localparam longint TURN_MAX = (longint'(1) <<< (COUNT_WIDTH - 1)) - 1;
    localparam longint TURN_MIN = -TURN_MAX - 1;
    localparam longint OFFSET_MAX = (longint'(1) <<< (OFFSET_W - 1)) - 1;
    localparam longint OFFSET_MIN = -OFFSET_MAX - 1;

    typedef struct {
        logic signed [YAW_W-1:0]    in_yaw;
        mode_t                      in_mode;
        logic signed [OFFSET_W-1:0] want;
    } offset_expect_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [YAW_W-1:0]    yaw = '0;
    logic [MODE_W-1:0]          mode = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [OFFSET_W-1:0] offset;

    // Predictor state: previous sample and turn count.
    logic signed [YAW_W-1:0]       trk_last_yaw = '0;
    logic signed [COUNT_WIDTH-1:0] trk_turns = '0;

    offset_expect_t pending_offsets[$];
    int mismatch_count = 0;

    // Sender pacing.
    bit tx_paced = 1'b1;
    int tx_burst_left = 0;
    int wander_yaw = 0;

    // Receiver pattern and long hold-off.
    bit rx_steady = 1'b0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int rx_phase = 0;
    int rx_period = 1;
    int rx_duty = 1;

    yaw_unwrap_base_offset_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .yaw       (yaw),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .offset    (offset)
    );

    always #5 clk = ~clk;

    function automatic longint fold_offset(input longint absang, input longint step,
                                           input longint half);
        longint d;
        d = absang - (absang / step) * step;
        if (d > half)
            d = d - step;
        else if (d < -half)
            d = d + step;
        return d;
    endfunction

    // Updates the turn tracking for one sample and returns the expected offset.
    function automatic logic signed [OFFSET_W-1:0] track_and_offset(
        input logic signed [YAW_W-1:0] y, input mode_t m);
        int     diff;
        longint absang;
        longint r;
        diff = int'(y) - int'(trk_last_yaw);
        if (diff > HALF_TURN) begin
            if (trk_turns > TURN_MIN)
                trk_turns = trk_turns - 1'b1;
        end
        else if (diff < -HALF_TURN) begin
            if (trk_turns < TURN_MAX)
                trk_turns = trk_turns + 1'b1;
        end
        trk_last_yaw = y;
        absang = longint'(trk_turns) * FULL_TURN + longint'(y);
        case (m)
            MODE_HALF:    r = fold_offset(absang, HALF_TURN, QUARTER_TURN);
            MODE_QUARTER: r = fold_offset(absang, QUARTER_TURN, EIGHTH_TURN);
            default:
            begin
                r = absang;
                if (r > OFFSET_MAX)
                    r = OFFSET_MAX;
                else if (r < OFFSET_MIN)
                    r = OFFSET_MIN;
            end
        endcase
        return r[OFFSET_W-1:0];
    endfunction

    // Mostly a wrapped random walk, with some uniform and some raw 17-bit values.
    function automatic logic signed [YAW_W-1:0] pick_yaw();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            wander_yaw = wander_yaw + int'($urandom_range(0, 12000)) - 6000;
            if (wander_yaw > HALF_TURN)
                wander_yaw = wander_yaw - FULL_TURN;
            else if (wander_yaw < -HALF_TURN)
                wander_yaw = wander_yaw + FULL_TURN;
            return YAW_W'(wander_yaw);
        end
        else if (pick < 90)
            return YAW_W'(int'($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN);
        return YAW_W'($urandom);
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    task automatic send_sample(input logic signed [YAW_W-1:0] y, input mode_t m);
        offset_expect_t rec;
        int gap;
        if (tx_paced) begin
            if (tx_burst_left == 0) begin
                gap = $urandom_range(1, 8);
                tx_burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 24);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            tx_burst_left--;
        end
        in_valid <= 1'b1;
        yaw      <= y;
        mode     <= m;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rec.in_yaw  = y;
        rec.in_mode = m;
        rec.want    = track_and_offset(y, m);
        pending_offsets.push_back(rec);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_sample(pick_yaw(), mode_t'($urandom_range(0, 3)));
    endtask

    // Three samples that make one turn and come back to zero.
    task automatic one_turn(input bit forward);
        int s;
        s = forward ? -1 : 1;
        send_sample(YAW_W'(s * (HALF_TURN + 1)), mode_t'($urandom_range(0, 3)));
        send_sample(YAW_W'(s * QUARTER_TURN), mode_t'($urandom_range(0, 3)));
        send_sample('0, mode_t'($urandom_range(0, 3)));
    endtask

    task automatic test_directed_corners();
        int corner_yaw[20] = '{0, 18000, 0, 18001, 0, 9000, 9001, -9000, -9001,
                               4500, 4501, -4500, -4501, 36000, -36000,
                               65535, -65536, -1, 27000, -27000};
        mode_t corner_mode[20] = '{MODE_ABSOLUTE, MODE_HALF, MODE_QUARTER,
                                   MODE_ABSOLUTE, MODE_ABS_ALT, MODE_HALF,
                                   MODE_HALF, MODE_HALF, MODE_HALF, MODE_QUARTER,
                                   MODE_QUARTER, MODE_QUARTER, MODE_QUARTER,
                                   MODE_ABSOLUTE, MODE_HALF, MODE_QUARTER,
                                   MODE_ABSOLUTE, MODE_HALF, MODE_QUARTER,
                                   MODE_ABS_ALT};
        for (int i = 0; i < 20; i++)
            send_sample(YAW_W'(corner_yaw[i]), corner_mode[i]);
    endtask

    task automatic test_random_walk();
        send_random(650);
    endtask

    // The receiver holds off while the sender keeps offering back to back.
    task automatic test_output_hold();
        tx_paced = 1'b0;
        hold_req <= hold_req + 1;
        send_random(40);
        tx_paced = 1'b1;
    endtask

    task automatic test_drain_and_resume();
        send_random(20);
        in_valid <= 1'b0;
        while (pending_offsets.size() != 0)
            @(posedge clk);
        send_random(20);
    endtask

    // Runs of whole turns forward and then backward past zero.
    task automatic test_turn_runs();
        tx_paced  = 1'b0;
        rx_steady = 1'b1;
        send_sample('0, MODE_ABSOLUTE);
        repeat (20) one_turn(1'b1);
        repeat (40) one_turn(1'b0);
        rx_steady = 1'b0;
        tx_paced  = 1'b1;
    endtask

    always @(posedge clk) begin : rx_pattern
        int np;
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (rx_steady) begin
            out_ready <= 1'b1;
        end
        else begin
            if (rx_phase + 1 >= rx_period) begin
                np = $urandom_range(1, 12);
                rx_phase  <= 0;
                rx_period <= np;
                rx_duty   <= $urandom_range(1, np);
            end
            else begin
                rx_phase <= rx_phase + 1;
            end
            out_ready <= (rx_phase < rx_duty);
        end
    end

    always @(posedge clk) begin : offset_check
        offset_expect_t exp_rec;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            if (pending_offsets.size() == 0) begin
                note_failure($sformatf("unexpected offset %0d with no sample pending",
                                       offset));
            end
            else begin
                exp_rec = pending_offsets.pop_front();
                if (offset !== exp_rec.want)
                    note_failure($sformatf(
                        "offset mismatch: yaw=%0d mode=%0d expected %0d got %0d",
                        exp_rec.in_yaw, exp_rec.in_mode, exp_rec.want, offset));
            end
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_random_walk();
        test_output_hold();
        test_drain_and_resume();
        test_turn_runs();
        in_valid <= 1'b0;
        while (pending_offsets.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
rtl/yawu_pkg.sv
rtl/yawu_offset_calc.sv
rtl/yaw_unwrap_base_offset_unit.sv
tb/testbench.sv
